// ----- rtl/radix52_limb_arith_stream_macros.svh -----
// Assertion macros shared by the checker of the radix-2^52 limb stream.
// No dependencies; include by bare file name.
`ifndef RADIX52_LIMB_ARITH_STREAM_MACROS_SVH
`define RADIX52_LIMB_ARITH_STREAM_MACROS_SVH

// Check a property on every rising edge of clk, masked while reset is low.
`define R52LA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge of clk, reset included.
`define R52LA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/r52la_pkg.sv -----
// Types and constants for the radix-2^52 limb add/sub/shift/compare stream.
// No dependencies; imported by the datapath, the top level and the checker.
package r52la_pkg;

  localparam int DIGIT_BITS = 52;
  localparam int SHIFT_W    = 6;
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 112;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_SHL = 2'd2,
    MODE_CMP = 2'd3
  } mode_t;

  typedef logic [DIGIT_BITS-1:0] digit_t;

  typedef struct packed {
    mode_t              mode;
    digit_t             a_digit;
    digit_t             b_digit;
    logic [SHIFT_W-1:0] shift_amount;
    logic               first;
    logic               last;
  } item_t;

  typedef struct packed {
    digit_t carry;
    logic   decided;
    logic   gte;
  } state_t;

  typedef struct packed {
    digit_t result_digit;
    digit_t carry_word;
    logic   greater_equal;
    logic   final_limb;
  } result_t;

endpackage

// ----- rtl/radix52_limb_arith_stream.sv -----
// Top level of the radix-2^52 multiprecision limb stream (add/sub/shift/compare).
// Depends on r52la_pkg and r52la_alu.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+------------------------------------------
//  in      | in  | in_tvalid/in_tready | in_tdata (mode,a,b,shift), in_tuser, in_tlast
//  out     | out | out_tvalid/out_tready | out_tdata (result,carry,ge), out_tlast
//
// One limb per cycle sustained while out is not stalled. An input transfer
// goes into the input register, then through the single-pass limb datapath
// into the result register. The carry/compare state updates as an item leaves the
// input register, so the running carry loop is one 53-bit add per cycle.
// Reset (rst_n low, synchronous) empties both stages and clears the carry
// word and compare flags. A stall on out holds the result; the input register
// still takes one more transfer before in_tready drops.
module radix52_limb_arith_stream
  import r52la_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [1:0] mode, [53:2] a_digit, [105:54] b_digit, [111:106] shift_amount
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [0] first
  input  logic                  in_tuser,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [51:0] result_digit, [103:52] carry_word, [104] greater_equal, [111:105] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  item_t   item_r, item_nxt;
  logic    s1_valid_r, s1_valid_nxt;
  result_t res_r, res_nxt;
  logic    out_valid_r, out_valid_nxt;
  state_t  state_r, state_nxt;
  state_t  alu_state;
  result_t alu_res;
  logic    in_xfer;
  logic    out_adv;

  // Result register may load when empty or when its content transfers now.
  assign out_adv   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_adv;
  assign in_xfer   = in_tvalid && in_tready;

  r52la_alu u_alu (
    .item_i  (item_r),
    .state_i (state_r),
    .state_o (alu_state),
    .res_o   (alu_res)
  );

  always_comb begin
    item_nxt      = item_r;
    s1_valid_nxt  = s1_valid_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    state_nxt     = state_r;

    if (out_adv) begin
      // Advance the input stage into the result register; commit state.
      out_valid_nxt = s1_valid_r;
      s1_valid_nxt  = 1'b0;
      if (s1_valid_r) begin
        res_nxt   = alu_res;
        state_nxt = alu_state;
      end
    end

    if (in_xfer) begin
      item_nxt.mode         = mode_t'(in_tdata[1:0]);
      item_nxt.a_digit      = in_tdata[2+DIGIT_BITS-1:2];
      item_nxt.b_digit      = in_tdata[2+2*DIGIT_BITS-1:2+DIGIT_BITS];
      item_nxt.shift_amount = in_tdata[2+2*DIGIT_BITS+SHIFT_W-1:2+2*DIGIT_BITS];
      item_nxt.first        = in_tuser;
      item_nxt.last         = in_tlast;
      s1_valid_nxt          = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-2*DIGIT_BITS-1){1'b0}}, res_r.greater_equal,
                       res_r.carry_word, res_r.result_digit};
  assign out_tlast  = res_r.final_limb;

endmodule

// ----- rtl/r52la_alu.sv -----
// One-limb datapath: add with carry, subtract with borrow, shift left, compare.
// Depends on r52la_pkg.
module r52la_alu
  import r52la_pkg::*;
(
  input  item_t   item_i,
  input  state_t  state_i,
  output state_t  state_o,
  output result_t res_o
);

  state_t                  cur;
  logic                    cin;
  logic [DIGIT_BITS:0]     sum;
  logic [DIGIT_BITS:0]     diff;
  logic [SHIFT_W-1:0]      n_clip;
  logic [2*DIGIT_BITS-1:0] wide;

  // First limb of a number: start from a clean state.
  assign cur    = item_i.first ? '0 : state_i;
  assign cin    = (cur.carry != '0);
  assign sum    = {1'b0, item_i.a_digit} + {1'b0, item_i.b_digit}
                  + {{DIGIT_BITS{1'b0}}, cin};
  assign diff   = {1'b0, item_i.a_digit} - {1'b0, item_i.b_digit}
                  - {{DIGIT_BITS{1'b0}}, cin};
  // Distances past the limb width act as a full-limb shift.
  assign n_clip = (item_i.shift_amount > SHIFT_W'(DIGIT_BITS)) ?
                  SHIFT_W'(DIGIT_BITS) : item_i.shift_amount;
  assign wide   = {{DIGIT_BITS{1'b0}}, item_i.a_digit} << n_clip;

  always_comb begin
    state_o             = cur;
    res_o.result_digit  = '0;
    res_o.carry_word    = '0;
    res_o.greater_equal = 1'b0;
    res_o.final_limb    = item_i.last;
    unique case (item_i.mode)
      MODE_ADD: begin
        state_o.carry      = {{(DIGIT_BITS-1){1'b0}}, sum[DIGIT_BITS]};
        res_o.result_digit = sum[DIGIT_BITS-1:0];
        res_o.carry_word   = {{(DIGIT_BITS-1){1'b0}}, sum[DIGIT_BITS]};
      end
      MODE_SUB: begin
        // Sign bit of the 53-bit difference is the borrow out.
        state_o.carry      = {{(DIGIT_BITS-1){1'b0}}, diff[DIGIT_BITS]};
        res_o.result_digit = diff[DIGIT_BITS-1:0];
        res_o.carry_word   = {{(DIGIT_BITS-1){1'b0}}, diff[DIGIT_BITS]};
      end
      MODE_SHL: begin
        state_o.carry      = wide[2*DIGIT_BITS-1:DIGIT_BITS];
        res_o.result_digit = wide[DIGIT_BITS-1:0] | cur.carry;
        res_o.carry_word   = wide[2*DIGIT_BITS-1:DIGIT_BITS];
      end
      MODE_CMP: begin
        // Most significant limb first; the first unequal limb decides.
        if (!cur.decided && (item_i.a_digit != item_i.b_digit)) begin
          state_o.decided = 1'b1;
          state_o.gte     = (item_i.a_digit > item_i.b_digit);
        end
        res_o.greater_equal = state_o.gte || !state_o.decided;
      end
      default: begin
        state_o = cur;
      end
    endcase
  end

endmodule

// ----- rtl/r52la_checker.sv -----
// Port-level checker for the radix-2^52 limb stream, bound to the top level.
// Depends on r52la_pkg and radix52_limb_arith_stream_macros.svh.
`include "radix52_limb_arith_stream_macros.svh"

module r52la_checker
  import r52la_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  // A held result keeps its payload until it transfers.
  `R52LA_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "out payload changed while stalled")
  // Input back-pressure only appears behind a stalled, valid result.
  `R52LA_ASSERT(a_in_stall, !in_tready |-> out_tvalid && !out_tready, "in_tready low without output stall")
  // A set compare flag only comes from compare mode, where limb and carry are zero.
  `R52LA_ASSERT(a_ge_clean, out_tvalid && out_tdata[2*DIGIT_BITS] |-> out_tdata[2*DIGIT_BITS-1:0] == '0, "compare flag with nonzero limb or carry")
  // Reset empties the result register.
  `R52LA_ASSERT_RST(a_rst_empty, !rst_n |=> !out_tvalid, "out_tvalid high after reset")

endmodule

bind radix52_limb_arith_stream r52la_checker u_r52la_checker (.*);

// ----- verif/radix52_limb_arith_stream_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the radix-2^52 limb stream: watches both channels, predicts each limb result.
// Depends on r52la_pkg for the mode codes and the item/result layouts.
module radix52_limb_arith_stream_checker
  import r52la_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  in_tlast,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tlast,
  output int                    fail_count,
  output int                    pending,
  output int                    checked_count
);

  // Running state of the number in flight.
  digit_t  carry_acc;
  logic    cmp_done;
  logic    cmp_a_ge;
  result_t due_limbs[$];
  int      n_fail;
  int      n_checked;

  task automatic compute_limb(input item_t lim, output result_t r);
    logic [52:0] wide;
    logic [63:0] a64;
    logic [63:0] shl;
    logic        cin;
    int          shift_dist;
    begin
      r = '0;
      if (lim.first) begin
        carry_acc = '0;
        cmp_done  = 1'b0;
        cmp_a_ge  = 1'b0;
      end
      // any nonzero carry word counts as a carry-in of one
      cin = |carry_acc;
      a64 = {12'd0, lim.a_digit};
      case (lim.mode)
        MODE_ADD: begin
          wide = {1'b0, lim.a_digit} + {1'b0, lim.b_digit} + {52'd0, cin};
          carry_acc = {51'd0, wide[52]};
          r.result_digit = wide[51:0];
          r.carry_word = carry_acc;
        end
        MODE_SUB: begin
          wide = {1'b0, lim.a_digit} - {1'b0, lim.b_digit} - {52'd0, cin};
          carry_acc = {51'd0, (({1'b0, lim.b_digit} + {52'd0, cin}) > {1'b0, lim.a_digit})};
          r.result_digit = wide[51:0];
          r.carry_word = carry_acc;
        end
        MODE_SHL: begin
          // clamp to a full limb; the old carry word is ORed in as it stands
          shift_dist = (lim.shift_amount > DIGIT_BITS) ? DIGIT_BITS : int'(lim.shift_amount);
          shl = (a64 << shift_dist) | {12'd0, carry_acc};
          r.result_digit = shl[51:0];
          shl = a64 >> (DIGIT_BITS - shift_dist);
          carry_acc = shl[51:0];
          r.carry_word = carry_acc;
        end
        default: begin
          // most significant limb first; the first unequal limb decides
          if (!cmp_done) begin
            if (lim.a_digit > lim.b_digit) begin
              cmp_a_ge = 1'b1;
              cmp_done = 1'b1;
            end else if (lim.a_digit < lim.b_digit) begin
              cmp_a_ge = 1'b0;
              cmp_done = 1'b1;
            end
          end
          r.greater_equal = cmp_a_ge || !cmp_done;
        end
      endcase
      r.final_limb = lim.last;
    end
  endtask

  function automatic int field_bad(string fname, logic [51:0] want, logic [51:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    item_t   lim;
    result_t want;
    result_t got;
    int      bad;
    if (!rst_n) begin
      carry_acc = '0;
      cmp_done  = 1'b0;
      cmp_a_ge  = 1'b0;
      due_limbs.delete();
      n_fail    = 0;
      n_checked = 0;
    end else begin
      // results first: latency keeps a result from matching a same-edge input
      if (out_tvalid && out_tready) begin
        got.result_digit  = out_tdata[51:0];
        got.carry_word    = out_tdata[103:52];
        got.greater_equal = out_tdata[104];
        got.final_limb    = out_tlast;
        if (due_limbs.size() == 0) begin
          $display("%0t ns: result with nothing expected, actual data 0x%0h last %0b",
                   $time, out_tdata, out_tlast);
          n_fail++;
        end else begin
          want = due_limbs.pop_front();
          bad = field_bad("result_digit", want.result_digit, got.result_digit)
              + field_bad("carry_word", want.carry_word, got.carry_word)
              + field_bad("greater_equal", {51'd0, want.greater_equal},
                          {51'd0, got.greater_equal})
              + field_bad("final_limb", {51'd0, want.final_limb}, {51'd0, got.final_limb});
          if (bad != 0) n_fail++;
          n_checked++;
        end
      end
      if (in_tvalid && in_tready) begin
        lim.mode         = mode_t'(in_tdata[1:0]);
        lim.a_digit      = in_tdata[53:2];
        lim.b_digit      = in_tdata[105:54];
        lim.shift_amount = in_tdata[111:106];
        lim.first        = in_tuser;
        lim.last         = in_tlast;
        compute_limb(lim, want);
        due_limbs.push_back(want);
      end
    end
    fail_count    <= n_fail;
    checked_count <= n_checked;
    pending       <= due_limbs.size();
  end

endmodule

// ----- verif/radix52_limb_arith_stream_tb.sv -----
`timescale 1ns / 1ps
// Top of the limb stream testbench: clock, reset, stimulus, back-pressure and verdict.
// Depends on r52la_pkg, radix52_limb_arith_stream and radix52_limb_arith_stream_checker.
module radix52_limb_arith_stream_tb;
  import r52la_pkg::*;

  localparam digit_t DIG_MAX        = '1;
  localparam int     HOLD_CYCLES    = 400;   // receiver hold-off, long enough to fill the block
  localparam int     WATCHDOG_LIMIT = 3000;  // cycles with no transfer on either channel
  localparam int     TAIL_CYCLES    = 8;     // idle margin after the drain before the verdict

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  int fail_count;
  int pending;
  int checked_count;

  // Knobs shared between the stimulus and the receiver.
  logic gap_en   = 1'b1;
  logic stall_en = 1'b1;
  logic hold_req = 1'b0;
  int   n_sent   = 0;
  int   n_numbers = 0;

  radix52_limb_arith_stream dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  radix52_limb_arith_stream_checker u_scoreboard (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked_count(checked_count)
  );

  // 20 ns period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Limb values weighted toward the carry and borrow boundaries.
  function automatic digit_t pick_digit();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return DIG_MAX;
      2: return DIG_MAX - digit_t'($urandom_range(0, 3));
      3: return digit_t'(1) << $urandom_range(0, DIGIT_BITS - 1);
      4: return digit_t'($urandom_range(0, 15));
      default: return digit_t'({$urandom(), $urandom()});
    endcase
  endfunction

  // Mostly legal distances, sometimes at or past the limb width to hit the clamp.
  function automatic logic [SHIFT_W-1:0] pick_shift();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return SHIFT_W'(DIGIT_BITS - 1);
      2: return SHIFT_W'($urandom_range(DIGIT_BITS, 63));
      default: return SHIFT_W'($urandom_range(0, DIGIT_BITS - 1));
    endcase
  endfunction

  // Offer one limb and hold it until the block takes the transfer. Random gaps
  // drop tvalid and scramble tdata, so a stray sample would show up as an error.
  task automatic send_limb(input mode_t m, input digit_t a, input digit_t b,
                           input logic [SHIFT_W-1:0] sh, input logic f, input logic l);
    while (gap_en && $urandom_range(99) < 16) begin
      in_tvalid <= 1'b0;
      in_tdata  <= IN_DATA_W'({$urandom(), $urandom(), $urandom(), $urandom()});
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {sh, b, a, m};
    in_tuser  <= f;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    n_sent++;
  endtask

  // Drop tvalid and wait until the checker has nothing outstanding.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // One multi-limb number. Most are well formed (first on the opening limb,
  // last on the closing one, one mode); the rest scramble the markers and modes.
  task automatic send_number();
    int                 len;
    mode_t              m;
    logic [SHIFT_W-1:0] sh;
    logic               broken;
    logic               f;
    logic               l;
    digit_t             a;
    digit_t             b;
    len    = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
    m      = mode_t'($urandom_range(0, 3));
    sh     = pick_shift();
    broken = ($urandom_range(99) < 15);
    for (int i = 0; i < len; i++) begin
      f = (i == 0);
      l = (i == len - 1);
      if (broken) begin
        f  = ($urandom_range(0, 3) == 0);
        l  = ($urandom_range(0, 3) == 0);
        m  = mode_t'($urandom_range(0, 3));
        sh = pick_shift();
      end
      a = pick_digit();
      // equal leading limbs push the compare decision deeper into the number
      b = (m == MODE_CMP && $urandom_range(99) < 60) ? a : pick_digit();
      send_limb(m, a, b, sh, f, l);
    end
    n_numbers++;
  endtask

  task automatic run_numbers(input int target);
    int stop_at;
    stop_at = n_sent + target;
    while (n_sent < stop_at) send_number();
  endtask

  // Receiver: random stalls, none at all, or one long hold-off counted here.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_req = 1'b0;
      end else if (stall_en) begin
        out_tready <= ($urandom_range(99) >= 16);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: advance a count on every cycle without a transfer on either side.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
             $time, WATCHDOG_LIMIT, pending);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: carry out of an all-ones add, then carry in on a zero limb.
    send_limb(MODE_ADD, DIG_MAX, DIG_MAX, '0, 1'b1, 1'b0);
    send_limb(MODE_ADD, '0, '0, '0, 1'b0, 1'b1);
    // borrow out of zero minus one, borrow in on a zero limb, all-ones minus itself
    send_limb(MODE_SUB, '0, 52'd1, '0, 1'b1, 1'b0);
    send_limb(MODE_SUB, '0, '0, '0, 1'b0, 1'b1);
    send_limb(MODE_SUB, DIG_MAX, DIG_MAX, '0, 1'b1, 1'b1);
    // shift by zero, by the widest legal distance, by the limb width and past it
    send_limb(MODE_SHL, DIG_MAX, '0, '0, 1'b1, 1'b0);
    send_limb(MODE_SHL, DIG_MAX, DIG_MAX, 6'd51, 1'b0, 1'b0);
    send_limb(MODE_SHL, 52'h5555555555555, '0, 6'd52, 1'b0, 1'b0);
    send_limb(MODE_SHL, DIG_MAX, '0, 6'd63, 1'b0, 1'b1);
    // a wide spill word left behind acts as a carry-in of one
    send_limb(MODE_ADD, 52'd1, 52'd1, '0, 1'b0, 1'b0);
    send_limb(MODE_SHL, 52'h123456789abcd, '0, 6'd20, 1'b1, 1'b1);
    send_limb(MODE_SUB, 52'd5, 52'd2, '0, 1'b0, 1'b1);
    // stale add carry ORed into a shifted limb
    send_limb(MODE_ADD, DIG_MAX, 52'd1, '0, 1'b1, 1'b0);
    send_limb(MODE_SHL, DIG_MAX, '0, 6'd4, 1'b0, 1'b1);
    // compare: equal numbers, a decided greater, a decided less that stays less
    send_limb(MODE_CMP, 52'd5, 52'd5, '0, 1'b1, 1'b0);
    send_limb(MODE_CMP, DIG_MAX, DIG_MAX, '0, 1'b0, 1'b1);
    send_limb(MODE_CMP, DIG_MAX, '0, '0, 1'b1, 1'b1);
    send_limb(MODE_CMP, '0, 52'd1, '0, 1'b1, 1'b0);
    send_limb(MODE_CMP, DIG_MAX, '0, '0, 1'b0, 1'b1);
    // a compare in the middle leaves the carry word alone
    send_limb(MODE_ADD, DIG_MAX, DIG_MAX, '0, 1'b1, 1'b0);
    send_limb(MODE_CMP, 52'd1, 52'd2, '0, 1'b0, 1'b0);
    send_limb(MODE_ADD, '0, '0, '0, 1'b0, 1'b1);

    // Random numbers with gaps and stalls on both sides.
    run_numbers(350);
    // A long stretch at full rate, no idling anywhere.
    gap_en   = 1'b0;
    stall_en = 1'b0;
    run_numbers(300);
    // Hold the output off while limbs keep coming, so the block backs up.
    gap_en   = 1'b1;
    stall_en = 1'b1;
    hold_req = 1'b1;
    run_numbers(250);
    // Pause the sender until every result is back, then finish the random part.
    drain();
    run_numbers(430);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d limbs in %0d numbers across add, subtract, shift and compare,",
             n_sent, n_numbers);
    $display("with gaps, stalls, a %0d-cycle output hold-off; %0d results compared.",
             HOLD_CYCLES, checked_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatching results", fail_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/r52la_pkg.sv
rtl/r52la_alu.sv
rtl/radix52_limb_arith_stream.sv
rtl/r52la_checker.sv
verif/radix52_limb_arith_stream_checker.sv
verif/radix52_limb_arith_stream_tb.sv
